/* hw/rtl/ssh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared constants, types and helpers of the S4/S9 shower-shape block.
// ----------------------------------------------------------------------------
package ssh_pkg;

  localparam int PHI_RING = 360;
  localparam int EW       = 20;
  localparam int ETAW     = 8;
  localparam int PHIW     = 9;
  localparam int SUMW     = 24;

  localparam logic [PHIW-1:0]        PHI_RING_P = PHIW'(PHI_RING);
  localparam logic signed [ETAW-1:0] ETA_LOW    = -8'sd85;
  localparam logic signed [ETAW-1:0] ETA_HIGH   = 8'sd84;

  typedef logic signed [SUMW-1:0] sum_t;

  typedef struct packed {
    logic                   taken;
    logic signed [ETAW-1:0] eta;
    logic [PHIW-1:0]        phi;
  } seed_t;

  typedef struct packed {
    logic [3:0]             quad_hit;
    logic                   win_hit;
    logic                   bad;
    logic signed [ETAW-1:0] eta_c;
    logic [PHIW-1:0]        phi_c;
  } geom_t;

  typedef struct packed {
    sum_t s4;
    sum_t s9;
    logic err;
  } result_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUMW-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUMW-1){1'b0}}};

  function automatic sum_t sat_add(sum_t acc, logic signed [EW-1:0] e);
    logic signed [SUMW:0] s;
    s = {acc[SUMW-1], acc} + {{(SUMW+1-EW){e[EW-1]}}, e};
    if (s[SUMW] != s[SUMW-1]) begin
      return s[SUMW] ? SUM_MIN : SUM_MAX;
    end
    return s[SUMW-1:0];
  endfunction

  function automatic sum_t smax(sum_t a, sum_t b);
    return (b > a) ? b : a;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ssh_geom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_geom
// Index conversion, range check and seed-relative window classification.
// ----------------------------------------------------------------------------
module ssh_geom import ssh_pkg::*; (
  input  wire logic                   index_mode,
  input  wire logic signed [ETAW-1:0] eta_in,
  input  wire logic [PHIW-1:0]        phi_in,
  input  wire seed_t                  seed,
  output geom_t                       geom
);

  logic signed [ETAW-1:0] eta_c;
  logic [PHIW-1:0]        phi_c;
  logic                   bad;
  logic signed [ETAW-1:0] se;
  logic [PHIW-1:0]        sp;
  logic signed [ETAW:0]   deta;
  logic signed [PHIW:0]   d;
  logic [PHIW-1:0]        ad;
  logic                   near;
  logic signed [PHIW+1:0] m;
  logic signed [PHIW+1:0] dphi;
  logic                   win;
  logic                   dphi_le, dphi_ge, deta_le, deta_ge;

  always_comb begin
    eta_c = eta_in;
    phi_c = phi_in;
    bad   = 1'b0;
    if (index_mode) begin
      if (eta_in > 8'sd0) eta_c = eta_in - 8'sd1;
      if (phi_in >= PHI_RING_P) phi_c = phi_in - PHI_RING_P;
      bad = (phi_c >= PHI_RING_P) || (eta_c < ETA_LOW) || (eta_c > ETA_HIGH);
    end
  end

  // the seed compares against itself on the beat that takes it
  assign se = seed.taken ? seed.eta : eta_c;
  assign sp = seed.taken ? seed.phi : phi_c;

  assign deta = $signed({se[ETAW-1], se}) - $signed({eta_c[ETAW-1], eta_c});

  // wrapped phi distance: short way around the ring
  assign d    = $signed({1'b0, sp}) - $signed({1'b0, phi_c});
  assign ad   = d[PHIW] ? PHIW'(-d) : d[PHIW-1:0];
  assign near = {ad, 1'b0} < {1'b0, PHI_RING_P};
  assign m    = $signed({2'b00, PHI_RING_P}) - $signed({2'b00, ad});
  assign dphi = near ? {d[PHIW], d} : ((sp > phi_c) ? -m : m);

  assign win = (deta >= -9'sd1) && (deta <= 9'sd1) &&
               (dphi >= -11'sd1) && (dphi <= 11'sd1);

  assign dphi_le = dphi <= 11'sd0;
  assign dphi_ge = dphi >= 11'sd0;
  assign deta_le = deta <= 9'sd0;
  assign deta_ge = deta >= 9'sd0;

  always_comb begin
    geom.eta_c       = eta_c;
    geom.phi_c       = phi_c;
    geom.bad         = bad;
    geom.win_hit     = win && !bad;
    geom.quad_hit[0] = win && !bad && dphi_le && deta_le;
    geom.quad_hit[1] = win && !bad && dphi_ge && deta_le;
    geom.quad_hit[2] = win && !bad && dphi_le && deta_ge;
    geom.quad_hit[3] = win && !bad && dphi_ge && deta_ge;
  end

endmodule
`default_nettype wire

/* hw/rtl/ssh_accum.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_accum
// Seed register, saturating quadrant and window sums, cluster result.
// ----------------------------------------------------------------------------
module ssh_accum import ssh_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 last,
  input  wire logic signed [EW-1:0] energy,
  input  wire geom_t                geom,
  output seed_t                     seed,
  output result_t                   result
);

  seed_t seed_r, seed_nxt;
  sum_t  quad_r [4];
  sum_t  quad_nxt [4];
  sum_t  win_r, win_nxt;
  logic  err_r, err_nxt;
  sum_t  upd [4];
  sum_t  win_upd;
  logic  err_upd;

  assign seed = seed_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      upd[i] = geom.quad_hit[i] ? sat_add(quad_r[i], energy) : quad_r[i];
    end
    win_upd = geom.win_hit ? sat_add(win_r, energy) : win_r;
    err_upd = err_r || geom.bad;
  end

  always_comb begin
    seed_nxt = seed_r;
    win_nxt  = win_r;
    err_nxt  = err_r;
    for (int i = 0; i < 4; i++) begin
      quad_nxt[i] = quad_r[i];
    end
    if (step) begin
      if (last) begin
        // cluster done: clear for the next seed
        seed_nxt = '0;
        win_nxt  = '0;
        err_nxt  = 1'b0;
        for (int i = 0; i < 4; i++) begin
          quad_nxt[i] = '0;
        end
      end else begin
        if (!seed_r.taken) begin
          seed_nxt.taken = 1'b1;
          seed_nxt.eta   = geom.eta_c;
          seed_nxt.phi   = geom.phi_c;
        end
        win_nxt = win_upd;
        err_nxt = err_upd;
        for (int i = 0; i < 4; i++) begin
          quad_nxt[i] = upd[i];
        end
      end
    end
  end

  assign result.s4  = smax(smax(upd[0], upd[1]), smax(upd[2], upd[3]));
  assign result.s9  = win_upd;
  assign result.err = err_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      win_r  <= '0;
      err_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        quad_r[i] <= '0;
      end
    end else begin
      seed_r <= seed_nxt;
      win_r  <= win_nxt;
      err_r  <= err_nxt;
      for (int i = 0; i < 4; i++) begin
        quad_r[i] <= quad_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/shower_shape_s4_s9.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shower_shape_s4_s9
// S4 (largest 2x2 quadrant) and S9 (3x3 window) energy sums around a seed.
// ----------------------------------------------------------------------------
// Crystals of a cluster arrive one beat each, the first beat being the seed and
// tlast marking the final crystal. One crystal is taken every cycle while no
// last crystal waits for the output register: a beat is held in the input
// register, classified against the seed there and added into the saturating
// sums at the edge it leaves, so a new crystal can follow each clock. The
// result of a cluster is loaded into the output register at the edge its last
// crystal leaves the input register and is held until taken; crystals keep
// flowing while it waits unless another last crystal needs the output
// register. cfg_data[0] selects raw indices (1, reset value) or indices used
// as given (0); write it only between clusters.
// ----------------------------------------------------------------------------
module shower_shape_s4_s9 import ssh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: energy[19:0], eta_index[27:20], phi_index[36:28], zero pad
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tlast,
  // out_tdata: s4_max[23:0], s9_sum[47:24], range_error[48], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data
);

  logic                   index_mode_r;
  logic                   s1_valid_r, s1_valid_nxt;
  logic signed [EW-1:0]   energy_r;
  logic signed [ETAW-1:0] eta_r;
  logic [PHIW-1:0]        phi_r;
  logic                   s1_last_r;
  logic                   in_fire, s1_fire, out_free;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r;
  seed_t                  seed;
  geom_t                  geom;
  result_t                result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      index_mode_r <= cfg_data[0];
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  // a last crystal waits for a free output register
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      energy_r  <= in_tdata[19:0];
      eta_r     <= in_tdata[27:20];
      phi_r     <= in_tdata[36:28];
      s1_last_r <= in_tlast;
    end
  end

  ssh_geom u_geom (
    .index_mode (index_mode_r),
    .eta_in     (eta_r),
    .phi_in     (phi_r),
    .seed       (seed),
    .geom       (geom)
  );

  ssh_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_fire),
    .last   (s1_last_r),
    .energy (energy_r),
    .geom   (geom),
    .seed   (seed),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.err, out_r.s9, out_r.s4};

  a_last_loads_out : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_tvalid)
    else $error("last crystal did not produce a result beat");

  a_out_from_last : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_fire && s1_last_r))
    else $error("result beat without a last crystal");

  a_last_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && s1_valid_r && s1_last_r) |-> !in_tready)
    else $error("input taken while last crystal is stalled");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the S4/S9 shower-shape block.
// ----------------------------------------------------------------------------
// Crystal beats go in as clusters: a short directed table first, then random
// clusters around random seeds, with stray beats and broken clusters mixed in.
// Both index modes are run. A cluster model folds every accepted beat into its
// own seed, quadrant and window sums and queues the S4/S9 result on each last
// crystal. Results coming out are checked field by field, in order, against
// that queue. The sender idles in bursts and the receiver stalls on patterns.
// ----------------------------------------------------------------------------
module tb_top import ssh_pkg::*; ();

  localparam bit          MODE_GIVEN   = 1'b0;
  localparam bit          MODE_RAW     = 1'b1;
  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          N_DIRECTED   = 23;
  localparam int          N_PHASES     = 6;
  localparam int          PHASE_BEATS  = 320;

  typedef struct packed {
    logic signed [19:0] energy;
    logic signed [7:0]  eta;
    logic [8:0]         phi;
    logic               last;
  } crystal_t;

  // One table row; reps repeats the crystal, with last only on the final copy.
  typedef struct packed {
    bit mode;
    int reps;
    int energy;
    int eta;
    int phi;
    bit last;
    bit typed;
    int s4;
    int s9;
    bit err;
  } dir_step_t;

  localparam dir_step_t DIRECTED [N_DIRECTED] = '{
    // single crystals at the energy extremes, then an out-of-range seed
    '{MODE_RAW,    1,  524287,    1,   1, 1'b1, 1'b1,  524287,  524287, 1'b0},
    '{MODE_RAW,    1, -524288,   -1, 360, 1'b1, 1'b1, -524288, -524288, 1'b0},
    '{MODE_RAW,    1,    1000,  127, 511, 1'b1, 1'b1,       0,       0, 1'b1},
    // bad seed keeps its position, good neighbor still sums
    '{MODE_RAW,    1,    4242,  -86,   0, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,     100,  -85,   0, 1'b1, 1'b0,       0,       0, 1'b0},
    // phi wrap across the ring seam
    '{MODE_RAW,    1,     300,    5,   0, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,     200,    5, 359, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,     150,    5,   1, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,      77,    5,   2, 1'b1, 1'b0,       0,       0, 1'b0},
    // saturation both ways
    '{MODE_RAW,   17,  524287,    0, 200, 1'b1, 1'b1, 8388607, 8388607, 1'b0},
    '{MODE_RAW,   17, -524288,  -85, 300, 1'b1, 1'b1, -8388608, -8388608, 1'b0},
    // seven of the 3x3 cells around eta zero, plus a far crystal and a bad one
    '{MODE_RAW,    1,    1000,    1,  50, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,    2000,   -1,  49, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,    3000,    2,  51, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,    -500,    0,  51, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,     400,    2,  49, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,     250,   -1,  51, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,     125,    0,  49, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,    9000,   85,  50, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_RAW,    1,     777,   86,  50, 1'b1, 1'b0,       0,       0, 1'b0},
    // indices as given, phi beyond the ring
    '{MODE_GIVEN,  1,       7, -128, 511, 1'b1, 1'b1,       7,       7, 1'b0},
    '{MODE_GIVEN,  1,    1234,  127, 500, 1'b0, 1'b0,       0,       0, 1'b0},
    '{MODE_GIVEN,  1,     -55,  126, 141, 1'b1, 1'b0,       0,       0, 1'b0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data   = '0;

  // cluster model state
  bit      raw_mode = MODE_RAW;
  int      seed_eta;
  int      seed_phi;
  bit      seed_held;
  int      quad_acc [4];
  int      win_acc;
  bit      err_flag;
  result_t shape_due [$];

  int          fail_count   = 0;
  int          accepted     = 0;
  int          burst_left   = 0;
  int unsigned cycle_count  = 0;
  logic [31:0] rx_tick      = '0;
  logic [1:0]  rx_style     = '0;
  logic [15:0] rx_mask      = 16'b1011_0111_0010_1111;
  result_t     want;
  sum_t        got_s4;
  sum_t        got_s9;
  logic        got_err;

  shower_shape_s4_s9 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: pick a new stall style whenever the low byte of rx_tick is zero
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick[7:0] == 8'd0) begin
      rx_style <= 2'($urandom_range(0, 3));
    end
    case (rx_style)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 2) != 0);
      2'd2:    out_tready <= rx_mask[rx_tick[3:0]];
      default: out_tready <= (rx_tick[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_s4  = out_tdata[23:0];
      got_s9  = out_tdata[47:24];
      got_err = out_tdata[48];
      if (shape_due.size() == 0) begin
        $error("unexpected result beat: s4_max=%0d s9_sum=%0d range_error=%0d",
               got_s4, got_s9, got_err);
        fail_count++;
      end else begin
        want = shape_due.pop_front();
        if (got_s4 !== want.s4) begin
          $error("s4_max mismatch: expected %0d, got %0d", want.s4, got_s4);
          fail_count++;
        end
        if (got_s9 !== want.s9) begin
          $error("s9_sum mismatch: expected %0d, got %0d", want.s9, got_s9);
          fail_count++;
        end
        if (got_err !== want.err) begin
          $error("range_error mismatch: expected %0d, got %0d", want.err, got_err);
          fail_count++;
        end
      end
    end
  end

  function automatic int clamp_sum(int acc, int e);
    longint s;
    s = longint'(acc) + longint'(e);
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return int'(s);
  endfunction

  // signed phi offset from b to a, taking the short way around the ring
  function automatic int ring_delta(int a, int b);
    int d;
    int ad;
    int m;
    d  = a - b;
    ad = (d < 0) ? -d : d;
    if (ad < PHI_RING - ad) return d;
    m = PHI_RING - ad;
    if (a > b) m = -m;
    return m;
  endfunction

  task automatic fold_crystal(input crystal_t c, output bit done, output result_t r);
    int eta_v;
    int phi_v;
    int e_v;
    int deta;
    int dphi;
    int best;
    bit bad;
    e_v   = c.energy;
    eta_v = c.eta;
    phi_v = int'(c.phi);
    bad   = 1'b0;
    done  = 1'b0;
    r     = '0;
    if (raw_mode) begin
      if (eta_v > 0) eta_v--;
      if (phi_v > PHI_RING - 1) phi_v -= PHI_RING;
      if (phi_v > PHI_RING - 1 || phi_v < 0 || eta_v < ETA_LOW || eta_v > ETA_HIGH) begin
        bad = 1'b1;
      end
    end
    if (!seed_held) begin
      seed_eta  = eta_v;
      seed_phi  = phi_v;
      seed_held = 1'b1;
    end
    if (bad) begin
      err_flag = 1'b1;
    end else begin
      deta = seed_eta - eta_v;
      dphi = ring_delta(seed_phi, phi_v);
      if (deta >= -1 && deta <= 1 && dphi >= -1 && dphi <= 1) begin
        win_acc = clamp_sum(win_acc, e_v);
        if (dphi <= 0 && deta <= 0) quad_acc[0] = clamp_sum(quad_acc[0], e_v);
        if (dphi >= 0 && deta <= 0) quad_acc[1] = clamp_sum(quad_acc[1], e_v);
        if (dphi <= 0 && deta >= 0) quad_acc[2] = clamp_sum(quad_acc[2], e_v);
        if (dphi >= 0 && deta >= 0) quad_acc[3] = clamp_sum(quad_acc[3], e_v);
      end
    end
    if (c.last) begin
      best = quad_acc[0];
      for (int i = 1; i < 4; i++) begin
        if (quad_acc[i] > best) best = quad_acc[i];
      end
      r.s4  = sum_t'(best);
      r.s9  = sum_t'(win_acc);
      r.err = err_flag;
      done  = 1'b1;
      seed_eta  = 0;
      seed_phi  = 0;
      seed_held = 1'b0;
      for (int i = 0; i < 4; i++) quad_acc[i] = 0;
      win_acc  = 0;
      err_flag = 1'b0;
    end
  endtask

  // Drive one crystal beat; queue either the typed result or the model's.
  task automatic send_crystal(input crystal_t c, input bit typed, input result_t typed_res);
    bit      done;
    result_t r;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, c.phi, c.eta, c.energy};
    in_tlast  <= c.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accepted++;
    fold_crystal(c, done, r);
    if (done) shape_due.insert(shape_due.size(), typed ? typed_res : r);
  endtask

  task automatic write_mode(input bit m);
    in_tvalid <= 1'b0;
    while (shape_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    raw_mode = m;
    burst_left = 0;
  endtask

  function automatic logic signed [19:0] pick_energy(input int style);
    int v;
    int k;
    k = $urandom_range(0, 19);
    if (style == 1 || (style == 0 && k >= 13 && k < 16)) begin
      v = 524287 - int'($urandom_range(0, 2000));
    end else if (style == 2 || (style == 0 && k >= 16 && k < 18)) begin
      v = -524288 + int'($urandom_range(0, 2000));
    end else if (k < 13) begin
      v = int'($urandom_range(0, 8191)) - 4096;
    end else begin
      v = $urandom;
    end
    return 20'(v);
  endfunction

  task automatic random_phase(input int quota);
    int       stop_at;
    int       n;
    int       style;
    int       s_eta;
    int       s_phi;
    int       d_eta;
    int       d_phi;
    int       p;
    crystal_t c;
    stop_at = accepted + quota;
    while (accepted < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        // stray beats, may break or open a cluster
        repeat ($urandom_range(1, 4)) begin
          c.energy = 20'($urandom);
          c.eta    = 8'($urandom);
          c.phi    = 9'($urandom);
          c.last   = ($urandom_range(0, 3) == 0);
          send_crystal(c, 1'b0, '0);
        end
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        style = $urandom_range(0, 7);
        style = (style == 6) ? 1 : (style == 7) ? 2 : 0;
        s_eta = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 255)) - 128
                                            : int'($urandom_range(0, 180)) - 90;
        s_phi = $urandom_range(0, 511);
        for (int i = 0; i < n; i++) begin
          d_eta = (i == 0) ? 0 : int'($urandom_range(0, 4)) - 2;
          d_phi = (i == 0) ? 0 : int'($urandom_range(0, 4)) - 2;
          p = s_phi + d_phi;
          if (p < 0) p += PHI_RING;
          else if (p >= 512) p -= PHI_RING;
          else if (s_phi < PHI_RING && p >= PHI_RING) p -= PHI_RING;
          // sometimes use the raw alias above the ring
          if (raw_mode && p < 512 - PHI_RING && $urandom_range(0, 3) == 0) p += PHI_RING;
          c.energy = pick_energy(style);
          c.eta    = 8'(s_eta + d_eta);
          c.phi    = 9'(p);
          c.last   = (i == n - 1);
          send_crystal(c, 1'b0, '0);
        end
      end
    end
    // close any open cluster before the next mode write
    if (seed_held) begin
      c.energy = pick_energy(0);
      c.eta    = 8'($urandom);
      c.phi    = 9'($urandom);
      c.last   = 1'b1;
      send_crystal(c, 1'b0, '0);
    end
  endtask

  initial begin
    crystal_t  c;
    dir_step_t row;
    bit        m;
    for (int i = 0; i < 4; i++) quad_acc[i] = 0;
    seed_eta  = 0;
    seed_phi  = 0;
    seed_held = 1'b0;
    win_acc   = 0;
    err_flag  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(MODE_RAW);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.mode != raw_mode) write_mode(row.mode);
      c.energy = 20'(row.energy);
      c.eta    = 8'(row.eta);
      c.phi    = 9'(row.phi);
      for (int k = 0; k < row.reps; k++) begin
        c.last = row.last && (k == row.reps - 1);
        send_crystal(c, row.typed, {sum_t'(row.s4), sum_t'(row.s9), row.err});
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      m = (ph == N_PHASES - 1) ? 1'($urandom_range(0, 1)) : ((ph % 2) ? MODE_RAW : MODE_GIVEN);
      write_mode(m);
      random_phase(PHASE_BEATS);
    end

    in_tvalid <= 1'b0;
    while (shape_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ssh_pkg.sv
hw/rtl/ssh_geom.sv
hw/rtl/ssh_accum.sv
hw/rtl/shower_shape_s4_s9.sv
verif/tb_top.sv
